/* rtl/credit_flow_sender_defines.svh */
// assertion helpers for the credit flow sender
`ifndef CREDIT_FLOW_SENDER_DEFINES_SVH
`define CREDIT_FLOW_SENDER_DEFINES_SVH

// property that must hold at every clock outside reset
`define CFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen outside reset
`define CFS_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* rtl/cfs_pkg.sv */
package cfs_pkg;

  // transaction kinds
  typedef enum logic [1:0] {
    OP_BUF_READY = 2'd0,
    OP_TICK      = 2'd1,
    OP_GRANT     = 2'd2,
    OP_START     = 2'd3
  } cfs_op_t;

  // configuration register indexes
  localparam logic [1:0] REG_UNIT_IS_BYTES = 2'd0;
  localparam logic [1:0] REG_LOSS_POLICY   = 2'd1;
  localparam logic [1:0] REG_WAIT_LIMIT    = 2'd2;

  // loss policy codes
  localparam logic [1:0] POLICY_IGNORE  = 2'd0;
  localparam logic [1:0] POLICY_RESTORE = 2'd1;
  localparam logic [1:0] POLICY_RESEND  = 2'd2;

  localparam int unsigned END_MARK_BYTES  = 2;
  localparam int unsigned HEADER_SLACK    = 2;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [15:0] FRAME_EXTRA = 16'(END_MARK_BYTES + HEADER_SLACK);

  // one classified transaction between front and back
  typedef struct packed {
    cfs_op_t     op;
    logic [31:0] now_time;
    logic [15:0] frame_size;
    logic [15:0] credit_amount;
  } cfs_item_t;

  typedef struct packed {
    logic      valid;
    cfs_item_t item;
  } cfs_slot_t;

endpackage

/* rtl/cfs_front.sv */
module cfs_front (
  input  logic             valid,
  output logic             stall,
  input  logic [1:0]       action,
  input  logic [31:0]      now_time,
  input  logic [15:0]      buf_size,
  input  logic [15:0]      credit_amount,
  input  logic             q_full,
  output cfs_pkg::cfs_slot_t push
);
  import cfs_pkg::*;

  cfs_op_t op;

  // every 2-bit action code maps onto one transaction kind
  assign op = cfs_op_t'(action);

  assign stall = q_full;

  always_comb begin
    push.valid              = valid && !q_full;
    push.item.op            = op;
    push.item.now_time      = now_time;
    // frame size wraps modulo 2^16
    push.item.frame_size    = buf_size + FRAME_EXTRA;
    push.item.credit_amount = credit_amount;
  end

endmodule

/* rtl/cfs_queue.sv */
module cfs_queue #(
  parameter int unsigned DEPTH = cfs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cfs_pkg::cfs_slot_t push,
  input  logic               pop,
  output logic               full,
  output cfs_pkg::cfs_slot_t head
);
  import cfs_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  cfs_item_t     entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == FULL_COUNT);
  assign do_push = push.valid && !full;
  assign do_pop  = pop && (count != '0);

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_comb begin
    head.valid = (count != '0);
    head.item  = entries[rd_ptr];
  end

endmodule

/* rtl/cfs_back.sv */
module cfs_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [1:0]          wr_index,
  input  logic [31:0]         wr_data,
  input  cfs_pkg::cfs_slot_t  head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                sent,
  output logic [8:0]          seq_word,
  output logic [15:0]         frame_size,
  output logic signed [31:0]  credit_left,
  output logic                timed_out,
  output logic                abandoned,
  output logic                resend_request,
  output logic [31:0]         timeout_total
);
  import cfs_pkg::*;

  // configuration
  logic        unit_is_bytes;
  logic [1:0]  timeout_action;
  logic [31:0] wait_limit;

  // sender state
  logic [31:0] credit, credit_next;
  logic [7:0]  reply_index, reply_index_next;
  logic        first_pending, first_pending_next;
  logic [31:0] last_send_time, last_send_time_next;
  logic [31:0] last_grant_time, last_grant_time_next;
  logic [31:0] grant_history [4];
  logic [31:0] timeout_count, timeout_count_next;
  logic        shift_history;

  // result of the current transaction
  logic        r_sent, r_timed_out, r_abandoned, r_resend;
  logic [8:0]  r_seq;
  logic [15:0] r_size;
  logic [31:0] age;
  cfs_item_t   it;

  assign it  = head.item;
  assign pop = head.valid && (!out_valid || !out_stall);
  assign age = it.now_time - last_send_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_is_bytes  <= 1'b0;
      timeout_action <= POLICY_IGNORE;
      wait_limit     <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_UNIT_IS_BYTES: unit_is_bytes  <= wr_data[0];
        REG_LOSS_POLICY:   timeout_action <= wr_data[1:0];
        REG_WAIT_LIMIT:    wait_limit     <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    credit_next          = credit;
    reply_index_next     = reply_index;
    first_pending_next   = first_pending;
    last_send_time_next  = last_send_time;
    last_grant_time_next = last_grant_time;
    timeout_count_next   = timeout_count;
    shift_history        = 1'b0;
    r_sent               = 1'b0;
    r_seq                = '0;
    r_size               = '0;
    r_timed_out          = 1'b0;
    r_abandoned          = 1'b0;
    r_resend             = 1'b0;

    unique case (it.op)
      OP_BUF_READY: begin
        // release only while credit is strictly positive
        if (credit != '0 && !credit[31]) begin
          r_sent              = 1'b1;
          r_size              = it.frame_size;
          r_seq               = {first_pending, reply_index};
          first_pending_next  = 1'b0;
          reply_index_next    = reply_index + 8'd1;
          last_send_time_next = it.now_time;
          credit_next = unit_is_bytes ? credit - {16'd0, it.frame_size}
                                      : credit - 32'd1;
        end
      end
      OP_TICK: begin
        if (last_send_time != '0 && !unit_is_bytes && age > wait_limit) begin
          r_timed_out        = 1'b1;
          timeout_count_next = timeout_count + 32'd1;
          shift_history      = 1'b1;
          if (last_grant_time == grant_history[3]) begin
            // no grant over the last four timeouts
            r_abandoned         = 1'b1;
            last_send_time_next = '0;
          end else begin
            case (timeout_action)
              POLICY_IGNORE: last_send_time_next = '0;
              POLICY_RESTORE: begin
                credit_next         = credit + 32'd1;
                last_send_time_next = '0;
              end
              POLICY_RESEND: begin
                credit_next = credit + 32'd1;
                r_resend    = 1'b1;
              end
              default: ;
            endcase
          end
        end
      end
      OP_GRANT: begin
        credit_next          = credit + {16'd0, it.credit_amount};
        last_grant_time_next = it.now_time;
      end
      default: begin
        credit_next         = {16'd0, it.credit_amount};
        reply_index_next    = '0;
        first_pending_next  = 1'b1;
        last_send_time_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credit          <= '0;
      reply_index     <= '0;
      first_pending   <= 1'b1;
      last_send_time  <= '0;
      last_grant_time <= '0;
      grant_history   <= '{default: '0};
      timeout_count   <= '0;
    end else if (pop) begin
      credit          <= credit_next;
      reply_index     <= reply_index_next;
      first_pending   <= first_pending_next;
      last_send_time  <= last_send_time_next;
      last_grant_time <= last_grant_time_next;
      timeout_count   <= timeout_count_next;
      if (shift_history) begin
        grant_history[3] <= grant_history[2];
        grant_history[2] <= grant_history[1];
        grant_history[1] <= grant_history[0];
        grant_history[0] <= last_grant_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sent           <= r_sent;
      seq_word       <= r_seq;
      frame_size     <= r_size;
      credit_left    <= credit_next;
      timed_out      <= r_timed_out;
      abandoned      <= r_abandoned;
      resend_request <= r_resend;
      timeout_total  <= timeout_count_next;
    end
  end

endmodule

/* rtl/credit_flow_sender.sv */
// credit flow sender: releases ready buffers against a signed credit, charging one
// frame or the frame's bytes per release; when counting frames it checks on each
// periodic tick whether credit came back within wait_limit ticks of the last send,
// applying the loss policy or abandoning when four timeouts saw no new grant. every
// input transaction gives exactly one result transaction. one transaction per cycle
// is sustained while the output is not stalled: an accepted input is written into
// the queue, and the back unit pops it, updates all sender state and registers the
// result. a short queue between the classifying front and the back unit absorbs
// output stalls, so the input only stalls once the queue is full.
`include "credit_flow_sender_defines.svh"

module credit_flow_sender #(
  parameter int unsigned QUEUE_DEPTH = cfs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration writes
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [31:0]        wr_data,
  // input transactions
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic [31:0]        now_time,
  input  logic [15:0]        buf_size,
  input  logic [15:0]        credit_amount,
  // result transactions
  output logic               out_valid,
  input  logic               out_stall,
  output logic               sent,
  output logic [8:0]         seq_word,
  output logic [15:0]        frame_size,
  output logic signed [31:0] credit_left,
  output logic               timed_out,
  output logic               abandoned,
  output logic               resend_request,
  output logic [31:0]        timeout_total
);
  import cfs_pkg::*;

  cfs_slot_t push;
  cfs_slot_t head;
  logic      q_full;
  logic      pop;

  // front: classify the action and precompute the frame size
  cfs_front u_front (
    .valid         (in_valid),
    .stall         (in_stall),
    .action        (action),
    .now_time      (now_time),
    .buf_size      (buf_size),
    .credit_amount (credit_amount),
    .q_full        (q_full),
    .push          (push)
  );

  // decoupling queue between front and back
  cfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (q_full),
    .head (head)
  );

  // back: sender state, timeout handling and the output register
  cfs_back u_back (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sent           (sent),
    .seq_word       (seq_word),
    .frame_size     (frame_size),
    .credit_left    (credit_left),
    .timed_out      (timed_out),
    .abandoned      (abandoned),
    .resend_request (resend_request),
    .timeout_total  (timeout_total)
  );

  // abandon and resend only come out of a detected timeout
  `CFS_ASSERT(a_outcome_needs_timeout,
              out_valid && (abandoned || resend_request) |-> timed_out,
              "abandon or resend without timeout")
  // a release and a timeout never share one result
  `CFS_NEVER(a_sent_vs_timeout,
             out_valid && sent && (timed_out || abandoned),
             "release and timeout in one result")
  // a held result must not be overwritten from the queue
  `CFS_NEVER(a_no_pop_while_held,
             out_valid && out_stall && pop,
             "queue popped while result stalled")

endmodule
